[rtl/rwc_pkg.sv]
// Shared types, constants and the arctangent table for the raycast wall column unit.
// No dependencies; used by every other file in rtl/.
package rwc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int ANGLE_BITS   = 16;   // binary angle, 2^ANGLE_BITS per turn

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROJ_DIST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_N     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_S     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_E     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_W     = 3'd5;

    localparam logic [1:0] TEX_NORTH = 2'd0;
    localparam logic [1:0] TEX_SOUTH = 2'd1;
    localparam logic [1:0] TEX_EAST  = 2'd2;
    localparam logic [1:0] TEX_WEST  = 2'd3;

    localparam logic MODE_COLUMN = 1'b0;
    localparam logic MODE_ROW    = 1'b1;

    localparam logic [11:0] SCREEN_H_RST  = 12'd600;
    localparam logic [23:0] PROJ_DIST_RST = 24'd177357;
    localparam logic [23:0] TEX_DIMS_RST  = 24'd262208;

    localparam logic [32:0] CORDIC_GAIN_Q30 = 33'd652032874;
    localparam logic [30:0] ONE_Q30         = 31'h4000_0000;
    localparam logic [31:0] THREE_QUARTER   = 32'hC000_0000;
    localparam logic [15:0] HEIGHT_MAX      = 16'hFFFF;
    localparam logic [11:0] FIELD12_MAX     = 12'hFFF;

    typedef struct packed {
        logic                  mode;
        logic [23:0]           ray_distance;
        logic [ANGLE_BITS-1:0] ray_dir;
        logic [ANGLE_BITS-1:0] player_angle;
        logic [23:0]           hit_x;
        logic [23:0]           hit_y;
        logic                  hit_vertical;
        logic                  facing_up;
        logic                  facing_down;
        logic                  facing_left;
        logic                  facing_right;
        logic [11:0]           screen_row;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [11:0] wall_top;
        logic [11:0] wall_bottom;
        logic [1:0]  texture_index;
        logic [11:0] tex_column;
        logic [11:0] tex_row;
        logic [15:0] strip_height;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_status;

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic [31:0] atan_turn32(input logic [3:0] idx);
        logic [31:0] v;
        case (idx)
            4'd0:    v = 32'd536870912;
            4'd1:    v = 32'd316933406;
            4'd2:    v = 32'd167458907;
            4'd3:    v = 32'd85004756;
            4'd4:    v = 32'd42667331;
            4'd5:    v = 32'd21354465;
            4'd6:    v = 32'd10679838;
            4'd7:    v = 32'd5340245;
            4'd8:    v = 32'd2670163;
            4'd9:    v = 32'd1335087;
            4'd10:   v = 32'd667544;
            4'd11:   v = 32'd333772;
            4'd12:   v = 32'd166886;
            4'd13:   v = 32'd83443;
            4'd14:   v = 32'd41722;
            default: v = 32'd20861;
        endcase
        return v;
    endfunction

endpackage

[rtl/rwc_ifs.sv]
// Handshake channel interfaces: input items, result items and register writes.
// Depends on rwc_pkg for the payload types.
interface rwc_in_if;
    logic              valid;
    logic              ready;
    rwc_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rwc_out_if;
    logic               valid;
    logic               ready;
    rwc_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rwc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rwc_pkg::CFG_IDX_W-1:0]  index;
    logic [23:0]                    wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

[rtl/raycast_wall_column_texture_map.sv]
// Raycast wall column projection and texture mapping, one item at a time over two shared
// iterative units. A column item (mode 0) removes fisheye with a 16-step CORDIC cosine,
// multiplies once for the perpendicular distance and runs the radix-2 divider once for
// the strip height (TILE*plane/perp); the texture offset and the column scale are a mask
// and a shift, so TILE must be a power of two. The divider width is DW = 25 + log2(TILE).
// A ray a quarter turn or more off the view axis skips both units; a zero perpendicular
// distance skips the divider. A row item (mode 1) is one division, skipped when the row
// lies above the strip or no strip is set. The CORDIC and the divider set the time. The
// input is ready only when idle; a finished result waits in the output register, and a
// stalled output holds the sequencer in its last state. Register writes are always
// accepted and must only happen while the block is idle.
module raycast_wall_column_texture_map #(
    parameter int TILE = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rwc_in_if.sink    i_in,
    rwc_out_if.source o_out,
    rwc_cfg_if.sink   i_cfg
);
    localparam int DW = 24 + $clog2(TILE) + 1;   // TILE*plane and row*texh both fit
    localparam int VW = 24;
    localparam int TW = $clog2(TILE);
    localparam int OW = $clog2(TILE + 1);        // mirrored offset reaches TILE

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_CORD = 8'b00000010,
        S_MULT = 8'b00000100,
        S_HCHK = 8'b00001000,
        S_HDIV = 8'b00010000,
        S_COLM = 8'b00100000,
        S_ROWD = 8'b01000000,
        S_DONE = 8'b10000000
    } t_state;

    t_state n_state, r_state;

    // configuration
    logic [11:0] r_screen_h;
    logic [23:0] r_proj_dist;
    logic [23:0] r_tex_dims [4];

    // architectural state
    logic [15:0] r_cur_height;
    logic [1:0]  r_cur_tex;

    // item in flight
    logic        r_kind;
    logic [23:0] r_dist;
    logic [15:0] r_off_src;
    logic        r_mirror;
    logic [1:0]  r_tex;
    logic [15:0] r_height;
    logic [23:0] r_perp;
    logic [11:0] r_col;
    logic [11:0] r_trow;

    // shared unit controls
    logic              r_cor_go, n_cor_go;
    logic signed [31:0] r_cor_angle;
    logic              r_div_go, n_div_go;
    logic [DW-1:0]     r_div_a;
    logic [VW-1:0]     r_div_b;

    rwc_pkg::t_unit_status w_cor_st, w_div_st;
    logic [30:0]   w_cos;
    logic [DW-1:0] w_div_q;

    logic          r_out_valid;
    rwc_pkg::t_out_item r_out;

    rwc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cor_go),
        .i_angle (r_cor_angle),
        .o_status(w_cor_st),
        .o_cos   (w_cos)
    );

    rwc_divider #(.DW(DW), .VW(VW)) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_div_a),
        .i_divisor  (r_div_b),
        .o_status   (w_div_st),
        .o_quotient (w_div_q)
    );

    // ---------------- input decode ----------------
    logic        w_accept;
    logic [31:0] w_adiff;
    logic [31:0] w_d32;
    logic        w_behind;
    logic [1:0]  w_tex_sel;
    logic        w_mirror;
    logic [10:0] w_half;
    logic [14:0] w_cur_h2;
    logic [16:0] w_row_sum;
    logic [16:0] w_row_d;
    logic        w_row_zero;
    logic [11:0] w_tex_w;
    logic [11:0] w_tex_h;

    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // angle difference mod 2^ANGLE_BITS, scaled to 2^32 per turn
    assign w_adiff = 32'(i_in.data.ray_dir) - 32'(i_in.data.player_angle);
    assign w_d32   = w_adiff << (32 - rwc_pkg::ANGLE_BITS);
    // quarter turn or more off the view axis: cos <= 0
    assign w_behind = (w_d32[31] ^ w_d32[30]) || (w_d32 == rwc_pkg::THREE_QUARTER);

    always_comb begin
        if (i_in.data.facing_up && !i_in.data.hit_vertical)
            w_tex_sel = rwc_pkg::TEX_NORTH;
        else if (i_in.data.facing_down && !i_in.data.hit_vertical)
            w_tex_sel = rwc_pkg::TEX_SOUTH;
        else if (i_in.data.facing_right && i_in.data.hit_vertical)
            w_tex_sel = rwc_pkg::TEX_EAST;
        else
            w_tex_sel = rwc_pkg::TEX_WEST;
    end
    assign w_mirror = (i_in.data.facing_left && i_in.data.hit_vertical)
                   || (i_in.data.facing_down && !i_in.data.hit_vertical);

    assign w_half     = r_screen_h[11:1];
    assign w_cur_h2   = r_cur_height[15:1];
    assign w_row_sum  = {5'd0, i_in.data.screen_row} + {2'd0, w_cur_h2};
    assign w_row_d    = w_row_sum - {6'd0, w_half};
    assign w_row_zero = (r_cur_height == '0) || (w_row_sum < {6'd0, w_half});

    // one dims lookup: the stored strip texture while idle, else the item's decoded texture
    logic [23:0] w_dims;
    assign w_dims  = r_tex_dims[(r_state == S_IDLE) ? r_cur_tex : r_tex];
    assign w_tex_w = w_dims[23:12];
    assign w_tex_h = w_dims[11:0];

    // ---------------- datapath helpers ----------------
    logic [54:0]    w_perp_prod;
    logic [OW-1:0]  w_off_m;
    logic [OW+11:0] w_col_prod;
    logic [15:0]    w_hq_sat;
    logic [11:0]    w_rq_sat;

    assign w_perp_prod = 55'(r_dist) * 55'(w_cos);
    // hit offset mod TILE, mirrored for left facing vertical hits and down facing horizontal hits
    assign w_off_m     = r_mirror ? OW'(TILE) - OW'(r_off_src[TW-1:0])
                                  : OW'(r_off_src[TW-1:0]);
    assign w_col_prod  = (OW + 12)'(w_off_m) * (OW + 12)'(w_tex_w >> TW);
    assign w_hq_sat    = (w_div_q > DW'(rwc_pkg::HEIGHT_MAX)) ? rwc_pkg::HEIGHT_MAX
                                                              : w_div_q[15:0];
    assign w_rq_sat    = (w_div_q > DW'(rwc_pkg::FIELD12_MAX)) ? rwc_pkg::FIELD12_MAX
                                                               : w_div_q[11:0];

    // ---------------- sequencer ----------------
    logic w_out_free;
    assign w_out_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state  = r_state;
        n_cor_go = 1'b0;
        n_div_go = 1'b0;
        unique case (r_state)
            S_IDLE: if (w_accept) begin
                if (i_in.data.mode == rwc_pkg::MODE_ROW) begin
                    n_state  = w_row_zero ? S_DONE : S_ROWD;
                    n_div_go = !w_row_zero;
                end else begin
                    n_state  = w_behind ? S_COLM : S_CORD;
                    n_cor_go = !w_behind;
                end
            end
            S_CORD: if (w_cor_st.done) n_state = S_MULT;
            S_MULT: n_state = S_HCHK;
            S_HCHK: begin
                n_state  = (r_perp == '0) ? S_COLM : S_HDIV;
                n_div_go = (r_perp != '0);
            end
            S_HDIV: if (w_div_st.done) n_state = S_COLM;
            S_COLM: n_state = S_DONE;
            S_ROWD: if (w_div_st.done) n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cor_go     <= 1'b0;
            r_div_go     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cur_height <= '0;
            r_cur_tex    <= rwc_pkg::TEX_NORTH;
            r_screen_h   <= rwc_pkg::SCREEN_H_RST;
            r_proj_dist  <= rwc_pkg::PROJ_DIST_RST;
            r_tex_dims[0] <= rwc_pkg::TEX_DIMS_RST;
            r_tex_dims[1] <= rwc_pkg::TEX_DIMS_RST;
            r_tex_dims[2] <= rwc_pkg::TEX_DIMS_RST;
            r_tex_dims[3] <= rwc_pkg::TEX_DIMS_RST;
        end else begin
            r_state  <= n_state;
            r_cor_go <= n_cor_go;
            r_div_go <= n_div_go;

            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    rwc_pkg::REG_SCREEN_H:  r_screen_h    <= i_cfg.wdata[11:0];
                    rwc_pkg::REG_PROJ_DIST: r_proj_dist   <= i_cfg.wdata;
                    rwc_pkg::REG_TEX_N:     r_tex_dims[0] <= i_cfg.wdata;
                    rwc_pkg::REG_TEX_S:     r_tex_dims[1] <= i_cfg.wdata;
                    rwc_pkg::REG_TEX_E:     r_tex_dims[2] <= i_cfg.wdata;
                    rwc_pkg::REG_TEX_W:     r_tex_dims[3] <= i_cfg.wdata;
                    default: ;
                endcase
            end

            if (r_state == S_DONE && w_out_free)
                r_out_valid <= 1'b1;
            else if (o_out.ready)
                r_out_valid <= 1'b0;

            if (r_state == S_DONE && w_out_free && r_kind == rwc_pkg::MODE_COLUMN) begin
                r_cur_height <= r_height;
                r_cur_tex    <= r_tex;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: if (w_accept) begin
                r_kind      <= i_in.data.mode;
                r_dist      <= i_in.data.ray_distance;
                r_off_src   <= i_in.data.hit_vertical ? i_in.data.hit_y[23:8]
                                                      : i_in.data.hit_x[23:8];
                r_mirror    <= w_mirror;
                r_tex       <= w_tex_sel;
                r_height    <= rwc_pkg::HEIGHT_MAX;
                r_trow      <= '0;
                r_cor_angle <= signed'(w_d32);
                if (i_in.data.mode == rwc_pkg::MODE_ROW) begin
                    r_div_a <= DW'(w_row_d) * DW'(w_tex_h);
                    r_div_b <= VW'(r_cur_height);
                end
            end
            S_MULT: r_perp <= w_perp_prod[53:30];
            S_HCHK: begin
                r_div_a <= DW'(TILE) * DW'(r_proj_dist);
                r_div_b <= r_perp;
            end
            S_HDIV: if (w_div_st.done) r_height <= w_hq_sat;
            S_COLM: r_col <= w_col_prod[11:0];
            S_ROWD: if (w_div_st.done) r_trow <= w_rq_sat;
            default: ;
        endcase
    end

    // result assembly
    logic [15:0] w_sum;
    assign w_sum = {5'd0, w_half} + {1'b0, r_height[15:1]};

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out.result_kind <= r_kind;
            if (r_kind == rwc_pkg::MODE_COLUMN) begin
                r_out.wall_top <= ({4'd0, w_half} > {1'b0, r_height[15:1]})
                                  ? 12'(w_half - r_height[11:1]) : 12'd0;
                r_out.wall_bottom   <= (w_sum > {4'd0, r_screen_h}) ? r_screen_h
                                                                    : w_sum[11:0];
                r_out.texture_index <= r_tex;
                r_out.tex_column    <= r_col;
                r_out.tex_row       <= '0;
                r_out.strip_height  <= r_height;
            end else begin
                r_out.wall_top      <= '0;
                r_out.wall_bottom   <= '0;
                r_out.texture_index <= r_cur_tex;
                r_out.tex_column    <= '0;
                r_out.tex_row       <= r_trow;
                r_out.strip_height  <= r_cur_height;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // ---------------- assertions ----------------
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cor_st.busy && w_div_st.busy))
        else $error("cordic and divider busy together");

    a_row_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.result_kind) |->
        (o_out.data.wall_top == '0 && o_out.data.tex_column == '0))
        else $error("row result carries column fields");

    a_top_le_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.result_kind) |->
        (o_out.data.wall_top <= o_out.data.wall_bottom))
        else $error("wall top below wall bottom");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cor_st.busy || w_div_st.busy) |-> !i_in.ready)
        else $error("input ready while a unit is working");
endmodule

[rtl/rwc_cordic.sv]
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, giving cos in Q1.30.
// Depends on rwc_pkg (atan table, gain, status type).
module rwc_cordic (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [31:0]    i_angle,
    output rwc_pkg::t_unit_status o_status,
    output logic [30:0]           o_cos
);
    logic               r_busy;
    logic               r_done;
    logic [3:0]         r_step;
    logic signed [32:0] r_x;
    logic signed [32:0] r_y;
    logic signed [33:0] r_z;
    logic signed [32:0] w_dx;
    logic signed [32:0] w_dy;
    logic signed [33:0] w_atan;

    assign w_dx   = r_y >>> r_step;
    assign w_dy   = r_x >>> r_step;
    assign w_atan = signed'({2'b00, rwc_pkg::atan_turn32(r_step)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 4'd1;
                if (r_step == 4'(rwc_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= signed'(rwc_pkg::CORDIC_GAIN_Q30);
            r_y <= '0;
            r_z <= 34'(i_angle);
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - w_dx;
                r_y <= r_y + w_dy;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_dx;
                r_y <= r_y - w_dy;
                r_z <= r_z + w_atan;
            end
        end
    end

    // clamp to [0, 1.0]
    always_comb begin
        if (r_x[32])
            o_cos = '0;
        else if (r_x[31:0] > 32'(rwc_pkg::ONE_Q30))
            o_cos = rwc_pkg::ONE_Q30;
        else
            o_cos = r_x[30:0];
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
endmodule

[rtl/rwc_divider.sv]
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on rwc_pkg (status type). Divisor must be nonzero.
module rwc_divider #(
    parameter int DW = 32,
    parameter int VW = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DW-1:0]         i_dividend,
    input  logic [VW-1:0]         i_divisor,
    output rwc_pkg::t_unit_status o_status,
    output logic [DW-1:0]         o_quotient
);
    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_den;
    logic [VW:0]   w_trial;
    logic [VW:0]   w_diff;

    assign w_trial = {r_rem, r_q[DW-1]};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[VW]) begin
                r_rem <= w_diff[VW-1:0];
                r_q   <= {r_q[DW-2:0], 1'b1};
            end else begin
                r_rem <= w_trial[VW-1:0];
                r_q   <= {r_q[DW-2:0], 1'b0};
            end
        end
    end

    assign o_quotient    = r_q;
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
endmodule

[tb/tb_raycast_wall_column_texture_map.sv]
`timescale 1ns / 1ps
// Self-checking testbench for raycast_wall_column_texture_map: random and directed items,
// random stalls on both sides, results checked against an in-bench predictor.
// Depends on rwc_pkg, rwc_ifs.sv and the block itself.
module tb_raycast_wall_column_texture_map;

    localparam int TILE_SZ       = 64;
    localparam int IDLE_LIMIT    = 5000;  // cycles with no handshake before giving up
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 150;   // longer than one column item

    // Tracks the block's registers and strip state, predicts each result item.
    class column_scoreboard;
        logic [11:0] screen_h;
        logic [23:0] plane_dist;
        logic [23:0] tex_dims [4];
        logic [15:0] strip_h;
        logic [1:0]  strip_tex;
        rwc_pkg::t_out_item pending [$];
        int          errors;
        longint      atan_tab [16];

        function new();
            atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                         10679838, 5340245, 2670163, 1335087, 667544, 333772,
                         166886, 83443, 41722, 20861};
            screen_h   = rwc_pkg::SCREEN_H_RST;
            plane_dist = rwc_pkg::PROJ_DIST_RST;
            foreach (tex_dims[i]) tex_dims[i] = rwc_pkg::TEX_DIMS_RST;
            strip_h    = '0;
            strip_tex  = rwc_pkg::TEX_NORTH;
            errors     = 0;
        endfunction

        function void write_reg(logic [rwc_pkg::CFG_IDX_W-1:0] idx, logic [23:0] v);
            case (idx)
                rwc_pkg::REG_SCREEN_H:  screen_h    = v[11:0];
                rwc_pkg::REG_PROJ_DIST: plane_dist  = v;
                rwc_pkg::REG_TEX_N:     tex_dims[0] = v;
                rwc_pkg::REG_TEX_S:     tex_dims[1] = v;
                rwc_pkg::REG_TEX_E:     tex_dims[2] = v;
                rwc_pkg::REG_TEX_W:     tex_dims[3] = v;
                default: ;
            endcase
        endfunction

        // Fixed 16-step CORDIC; z in 2^32-per-turn units. Returns cos in Q1.30.
        function longint cordic_cos(longint z);
            longint x, y, dx, dy;
            x = 652032874;
            y = 0;
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_tab[i];
                end else begin
                    x += dx; y -= dy; z += atan_tab[i];
                end
            end
            if (x < 0) x = 0;
            if (x > 64'sd1073741824) x = 64'sd1073741824;
            return x;
        endfunction

        function void note_input(rwc_pkg::t_in_item it);
            rwc_pkg::t_out_item exp_r;
            longint unsigned half, h2, height, d32, perp, q, off, width, d, trow;
            longint unsigned top, bottom;
            logic [1:0] tex;
            exp_r = '0;
            half  = screen_h >> 1;
            if (it.mode == rwc_pkg::MODE_COLUMN) begin
                height = 65535;
                d32 = {16'(it.ray_dir - it.player_angle), 16'h0};
                if (d32 < 64'h4000_0000 || d32 > 64'hC000_0000) begin
                    perp = (longint'(it.ray_distance) *
                            cordic_cos(d32 < 64'h4000_0000 ? d32 : d32 - 64'h1_0000_0000))
                           >> 30;
                    if (perp != 0) begin
                        q = (TILE_SZ * longint'(plane_dist)) / perp;
                        height = (q > 65535) ? 65535 : q;
                    end
                end
                h2 = height >> 1;
                if (it.facing_up && !it.hit_vertical) tex = rwc_pkg::TEX_NORTH;
                else if (it.facing_down && !it.hit_vertical) tex = rwc_pkg::TEX_SOUTH;
                else if (it.facing_right && it.hit_vertical) tex = rwc_pkg::TEX_EAST;
                else tex = rwc_pkg::TEX_WEST;
                off = (it.hit_vertical ? (it.hit_y >> 8) : (it.hit_x >> 8)) % TILE_SZ;
                if ((it.facing_left && it.hit_vertical) ||
                    (it.facing_down && !it.hit_vertical))
                    off = TILE_SZ - off;
                width  = tex_dims[tex][23:12];
                off    = off * (width / TILE_SZ);
                top    = (half > h2) ? half - h2 : 0;
                bottom = (half + h2 > screen_h) ? screen_h : half + h2;
                exp_r.result_kind   = rwc_pkg::MODE_COLUMN;
                exp_r.wall_top      = top[11:0];
                exp_r.wall_bottom   = bottom[11:0];
                exp_r.texture_index = tex;
                exp_r.tex_column    = off[11:0];
                exp_r.strip_height  = height[15:0];
                strip_h   = height[15:0];
                strip_tex = tex;
            end else begin
                h2   = strip_h >> 1;
                trow = 0;
                if (strip_h != 0 && it.screen_row + h2 >= half) begin
                    d    = it.screen_row + h2 - half;
                    trow = (d * tex_dims[strip_tex][11:0]) / strip_h;
                    if (trow > 4095) trow = 4095;
                end
                exp_r.result_kind   = rwc_pkg::MODE_ROW;
                exp_r.texture_index = strip_tex;
                exp_r.tex_row       = trow[11:0];
                exp_r.strip_height  = strip_h;
            end
            pending.push_back(exp_r);
        endfunction

        function void field_cmp(string name, longint unsigned e, longint unsigned a);
            if (e != a) begin
                $display("%0t mismatch %s: expected %0d, got %0d", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(rwc_pkg::t_out_item got);
            rwc_pkg::t_out_item e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result item: %p", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            field_cmp("result_kind",   e.result_kind,   got.result_kind);
            field_cmp("wall_top",      e.wall_top,      got.wall_top);
            field_cmp("wall_bottom",   e.wall_bottom,   got.wall_bottom);
            field_cmp("texture_index", e.texture_index, got.texture_index);
            field_cmp("tex_column",    e.tex_column,    got.tex_column);
            field_cmp("tex_row",       e.tex_row,       got.tex_row);
            field_cmp("strip_height",  e.strip_height,  got.strip_height);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    rwc_in_if  in_ch();
    rwc_out_if out_ch();
    rwc_cfg_if cfg_ch();

    raycast_wall_column_texture_map dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    column_scoreboard sb = new();
    bit burst_mode;        // when set, sender and receiver add no random gaps
    bit hold_request;      // asks the receiver for one long hold-off
    int idle_cycles = 0;

    // Watchdog: any handshake restarts the count.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random ready gaps, one long hold-off on request.
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = burst_mode ? 0 : $urandom_range(0, 11);
            if (hold_request) begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                out_ch.ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            sb.check_result(out_ch.data);
            @(negedge i_clk);
        end
    end

    // Offers one item after a gap; valid stays high when the gap is zero.
    task automatic send_item(rwc_pkg::t_in_item it);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = it;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(it);
        @(negedge i_clk);
    endtask

    // Lets the block drain: all results back, then a settle period.
    task automatic drain();
        in_ch.valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [rwc_pkg::CFG_IDX_W-1:0] idx, logic [23:0] v);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.wdata = v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.write_reg(idx, v);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic write_all(logic [11:0] sh, logic [23:0] pd, logic [23:0] tn,
                             logic [23:0] ts, logic [23:0] te, logic [23:0] tw);
        write_reg(rwc_pkg::REG_SCREEN_H, {12'h0, sh});
        write_reg(rwc_pkg::REG_PROJ_DIST, pd);
        write_reg(rwc_pkg::REG_TEX_N, tn);
        write_reg(rwc_pkg::REG_TEX_S, ts);
        write_reg(rwc_pkg::REG_TEX_E, te);
        write_reg(rwc_pkg::REG_TEX_W, tw);
    endtask

    function automatic rwc_pkg::t_in_item column_item(logic [23:0] ray_len, logic [15:0] ray,
                                                      logic [15:0] player, logic [23:0] hx,
                                                      logic [23:0] hy, logic [4:0] flags);
        rwc_pkg::t_in_item it;
        it = '0;
        it.mode = rwc_pkg::MODE_COLUMN;
        it.ray_distance = ray_len;
        it.ray_dir = ray;
        it.player_angle = player;
        it.hit_x = hx;
        it.hit_y = hy;
        {it.hit_vertical, it.facing_up, it.facing_down, it.facing_left, it.facing_right} = flags;
        return it;
    endfunction

    function automatic rwc_pkg::t_in_item row_item(logic [11:0] row);
        rwc_pkg::t_in_item it;
        it = rwc_pkg::t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.mode = rwc_pkg::MODE_ROW;
        it.screen_row = row;
        return it;
    endfunction

    // Random item: mostly rays in front of the view at useful distances,
    // rows inside the current strip half of the time.
    function automatic rwc_pkg::t_in_item random_item();
        rwc_pkg::t_in_item it;
        logic [15:0] diff;
        int          sel, lo, hi;
        it = rwc_pkg::t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom});
        if ($urandom_range(0, 9) < 4) begin
            it.mode = rwc_pkg::MODE_ROW;
            if ($urandom_range(0, 1)) begin
                lo = int'(sb.screen_h >> 1) - int'(sb.strip_h >> 1);
                hi = int'(sb.screen_h >> 1) + int'(sb.strip_h >> 1);
                if (lo < 0) lo = 0;
                if (hi > 4095) hi = 4095;
                it.screen_row = 12'($urandom_range(lo, hi));
            end
            return it;
        end
        it.mode = rwc_pkg::MODE_COLUMN;
        sel = $urandom_range(0, 9);
        if (sel < 8)
            diff = $urandom_range(0, 1) ? 16'($urandom_range(0, 16'h3FFF))
                                        : 16'(-$urandom_range(0, 16'h3FFF));
        else
            diff = 16'($urandom);
        it.ray_dir = it.player_angle + diff;
        sel = $urandom_range(0, 9);
        if (sel == 0) it.ray_distance = '0;
        else if (sel < 3) it.ray_distance = 24'($urandom_range(1, 255));
        else if (sel < 8) it.ray_distance = 24'($urandom_range(256, 24'h10000));
        return it;
    endfunction

    task automatic random_phase(int n, bit with_hold);
        for (int k = 0; k < n; k++) begin
            if (k % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            if (with_hold && k == n / 2) begin
                burst_mode = 1'b1;
                hold_request = 1'b1;
            end
            send_item(random_item());
        end
        burst_mode = 1'b0;
        drain();
    endtask

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = rwc_pkg::REG_SCREEN_H;
        cfg_ch.wdata = '0;
        burst_mode   = 1'b0;
        hold_request = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: row lookup before any strip exists gives row 0
        send_item(row_item(12'd300));
        // zero distance and straight ahead: saturated height
        send_item(column_item(24'd0, 16'd0, 16'd0, 24'h0, 24'h0, 5'b01000));
        send_item(row_item(12'd0));
        send_item(row_item(12'hFFF));
        // far wall, every texture choice and mirror
        send_item(column_item(24'hFFFFFF, 16'h1000, 16'h1000, 24'hFFFFFF, 24'h0, 5'b01000));
        send_item(column_item(24'h2000, 16'h0100, 16'h0000, 24'h4000, 24'h0, 5'b00100));
        send_item(column_item(24'h2000, 16'hFF00, 16'h0000, 24'h0, 24'h1234, 5'b10001));
        send_item(column_item(24'h2000, 16'h0000, 16'hFFFF, 24'h0, 24'h4000, 5'b10010));
        send_item(column_item(24'h1800, 16'h0200, 16'h0000, 24'h0, 24'hFFFFFF, 5'b11111));
        send_item(column_item(24'h1800, 16'h0200, 16'h0000, 24'h0, 24'h0, 5'b00000));
        send_item(row_item(12'd250));
        send_item(row_item(12'd10));
        // behind the view: quarter turn each way, and just inside
        send_item(column_item(24'h4000, 16'h4000, 16'h0000, 24'h1000, 24'h0, 5'b01000));
        send_item(column_item(24'h4000, 16'h0000, 16'h4000, 24'h1000, 24'h0, 5'b01000));
        send_item(column_item(24'h4000, 16'h0000, 16'h3FFF, 24'h1000, 24'h0, 5'b01000));
        send_item(column_item(24'h0040, 16'hFFFF, 16'h0000, 24'hABCDEF, 24'h0, 5'b00101));
        send_item(row_item(12'd599));
        send_item(row_item(12'hFFF));
        send_item(column_item(24'h0001, 16'h3FFF, 16'h0000, 24'h0, 24'h0, 5'b00110));
        send_item(row_item(12'd0));
        drain();

        random_phase(300, 1'b0);
        // Extremes: tallest screen, largest plane and textures
        write_all(12'hFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        random_phase(300, 1'b1);
        // One-line screen, zero plane, empty textures
        write_all(12'd1, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        random_phase(250, 1'b0);
        write_all(12'd0, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                  24'($urandom));
        random_phase(250, 1'b0);
        write_all(12'd480, 24'd150000, {12'd128, 12'd128}, {12'd32, 12'd64},
                  {12'd256, 12'd4095}, {12'd64, 12'd16});
        random_phase(350, 1'b0);
        write_all(12'($urandom), 24'($urandom_range(1000, 500000)), 24'($urandom),
                  24'($urandom), 24'($urandom), 24'($urandom));
        random_phase(330, 1'b0);

        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

[filelist.f]
rtl/rwc_pkg.sv
rtl/rwc_ifs.sv
rtl/rwc_cordic.sv
rtl/rwc_divider.sv
rtl/raycast_wall_column_texture_map.sv
tb/tb_raycast_wall_column_texture_map.sv
